@@ src/pmfp_pkg.sv @@
package pmfp_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LEN = 24;
  localparam int unsigned IDX_W     = 5;

  // Header bytes
  localparam logic [7:0] HDR_A = 8'h55;
  localparam logic [7:0] HDR_B = 8'hF2;
  localparam logic [7:0] HDR_2 = 8'h5A;

  // Byte positions inside a frame
  localparam logic [IDX_W-1:0] IDX_FIRST_DATA = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LAST       = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_END        = IDX_W'(FRAME_LEN);

  // Result item width: 1 + 8 + 6*24 + 8 + 32 = 193, padded to whole bytes
  localparam int unsigned RES_BITS = 193;
  localparam int unsigned RES_W    = 200;

  typedef logic [7:0] byte_t;

  // Result item fields
  typedef struct packed {
    logic [31:0] energy_total;
    logic [7:0]  status_byte;
    logic [23:0] power_raw;
    logic [23:0] power_param;
    logic [23:0] current_raw;
    logic [23:0] current_param;
    logic [23:0] voltage_raw;
    logic [23:0] voltage_param;
    logic [7:0]  header_byte;
    logic        checksum_ok;
  } result_t;

endpackage

@@ src/power_meter_frame_parser_unit.sv @@
// The result item is registered: it appears on m_tdata in the cycle after the last frame byte is accepted.
// Throughput: one byte per cycle; the single output register takes a new result
// in the cycle its previous one is taken, so only the last frame byte can stall.
// Reset (rst, synchronous, active high): parser hunts for a header, overflow
// counter and toggle bit cleared, no result pending; the frame store is not cleared.
module power_meter_frame_parser_unit (
  input  logic                        clk,
  input  logic                        rst,
  // slave side
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  // master side
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [0] checksum_ok, [8:1] header_byte, [32:9] voltage_param, [56:33] voltage_raw,
  // [80:57] current_param, [104:81] current_raw, [128:105] power_param,
  // [152:129] power_raw, [160:153] status_byte, [192:161] energy_total, [199:193] zero
  output logic [pmfp_pkg::RES_W-1:0]  m_tdata
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HDR2 = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]                   phase;
  logic [1:0]                   phase_next;
  logic [pmfp_pkg::IDX_W-1:0]   byte_index;
  logic [pmfp_pkg::IDX_W-1:0]   byte_index_next;
  logic [7:0]                   running_sum;
  logic [7:0]                   running_sum_next;
  pmfp_pkg::byte_t              frame_store [pmfp_pkg::FRAME_LEN];
  logic                         last_toggle_bit;
  logic [15:0]                  overflow_count;

  logic                         in_fire;
  logic                         out_fire;
  logic                         at_last;
  logic                         store_we;
  logic [pmfp_pkg::IDX_W-1:0]   store_idx;
  logic                         finish;
  logic                         sum_ok;
  logic                         toggled;
  logic [15:0]                  overflow_count_next;
  pmfp_pkg::result_t            res;
  pmfp_pkg::byte_t              b;

  assign b        = s_tdata;
  assign at_last  = (phase == PH_DATA) && (byte_index >= pmfp_pkg::IDX_LAST);
  assign out_fire = m_tvalid && m_tready;
  // stall only the byte that would create a result while the output is full
  assign s_tready = !(at_last && m_tvalid && !m_tready);
  assign in_fire  = s_tvalid && s_tready;

  // Frame parser next state
  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    store_we         = 1'b0;
    store_idx        = byte_index;
    finish           = 1'b0;
    case (phase)
      PH_HDR2: begin
        if (b == pmfp_pkg::HDR_2) begin
          store_we         = 1'b1;
          store_idx        = pmfp_pkg::IDX_W'(1);
          byte_index_next  = pmfp_pkg::IDX_FIRST_DATA;
          running_sum_next = 8'd0;
          phase_next       = PH_DATA;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_DATA: begin
        store_we        = (byte_index < pmfp_pkg::IDX_END);
        byte_index_next = byte_index + pmfp_pkg::IDX_W'(1);
        if (byte_index_next >= pmfp_pkg::IDX_END) begin
          finish     = 1'b1;
          phase_next = PH_HUNT;
        end else begin
          running_sum_next = running_sum + b;
        end
      end
      default: begin
        // hunting; the unused code behaves the same
        if (b == pmfp_pkg::HDR_A || b == pmfp_pkg::HDR_B) begin
          store_we   = 1'b1;
          store_idx  = '0;
          phase_next = PH_HDR2;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  // Result formation from the stored frame and the checksum byte
  assign sum_ok  = (running_sum == b);
  assign toggled = frame_store[20][7] != last_toggle_bit;
  assign overflow_count_next = overflow_count + 16'(toggled);

  always_comb begin
    res = '0;
    if (sum_ok) begin
      res.checksum_ok   = 1'b1;
      res.header_byte   = frame_store[0];
      res.voltage_param = {frame_store[2],  frame_store[3],  frame_store[4]};
      res.voltage_raw   = {frame_store[5],  frame_store[6],  frame_store[7]};
      res.current_param = {frame_store[8],  frame_store[9],  frame_store[10]};
      res.current_raw   = {frame_store[11], frame_store[12], frame_store[13]};
      res.power_param   = {frame_store[14], frame_store[15], frame_store[16]};
      res.power_raw     = {frame_store[17], frame_store[18], frame_store[19]};
      res.status_byte   = frame_store[20];
      res.energy_total  = {overflow_count_next, frame_store[21], frame_store[22]};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      byte_index      <= '0;
      running_sum     <= 8'd0;
      last_toggle_bit <= 1'b0;
      overflow_count  <= 16'd0;
    end else if (in_fire) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      if (finish && sum_ok) begin
        last_toggle_bit <= frame_store[20][7];
        overflow_count  <= overflow_count_next;
      end
    end
  end

  // Frame store, written one byte per accepted frame byte
  always_ff @(posedge clk) begin
    if (in_fire && store_we) begin
      frame_store[store_idx] <= b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire && finish) begin
      m_tvalid <= 1'b1;
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && finish) begin
      m_tdata <= {(pmfp_pkg::RES_W - pmfp_pkg::RES_BITS)'(0), res};
    end
  end

  // Checks
  a_result_follows_last_byte: assert property (@(posedge clk) disable iff (rst)
    (in_fire && at_last) |=> m_tvalid)
    else $error("last frame byte accepted without a result");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[pmfp_pkg::RES_BITS-1:1] == '0))
    else $error("bad frame result carries nonzero data");

  a_counter_moves_on_good_frame: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (overflow_count != $past(overflow_count))) |-> (m_tvalid && m_tdata[0]))
    else $error("overflow counter changed without a good frame");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && at_last))
    else $error("input stalled without a pending result");

endmodule

@@ tb/power_meter_frame_parser_unit_checker.sv @@
`timescale 1ns / 1ps

module power_meter_frame_parser_unit_checker
  import pmfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [RES_W-1:0] m_tdata,
  output int unsigned      fail_count,
  output int unsigned      pending_results,
  output int unsigned      good_frames,
  output int unsigned      bad_frames
);

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    COLLECT
  } parse_phase_e;

  // Predictor state
  parse_phase_e     phase;
  logic [IDX_W-1:0] byte_pos;
  byte_t            frame_sum;
  byte_t            frame_bytes [FRAME_LEN];
  logic             toggle_seen;
  logic [15:0]      overflow_cnt;

  // Results predicted but not yet seen on the master side
  result_t          expected_q [$];

  task automatic report_fail(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_fail($sformatf("%s got 0x%0h, expected 0x%0h", what, got, want));
  endtask

  // Last byte of a frame: build the decoded result or the all-zero one
  task automatic close_frame(input byte_t last);
    result_t r;
    r = '0;
    if (frame_sum == last) begin
      if (frame_bytes[20][7] != toggle_seen) begin
        overflow_cnt++;
        toggle_seen = frame_bytes[20][7];
      end
      r.checksum_ok   = 1'b1;
      r.header_byte   = frame_bytes[0];
      r.voltage_param = {frame_bytes[2], frame_bytes[3], frame_bytes[4]};
      r.voltage_raw   = {frame_bytes[5], frame_bytes[6], frame_bytes[7]};
      r.current_param = {frame_bytes[8], frame_bytes[9], frame_bytes[10]};
      r.current_raw   = {frame_bytes[11], frame_bytes[12], frame_bytes[13]};
      r.power_param   = {frame_bytes[14], frame_bytes[15], frame_bytes[16]};
      r.power_raw     = {frame_bytes[17], frame_bytes[18], frame_bytes[19]};
      r.status_byte   = frame_bytes[20];
      r.energy_total  = {overflow_cnt, frame_bytes[21], frame_bytes[22]};
      good_frames++;
    end else begin
      bad_frames++;
    end
    expected_q.push_back(r);
  endtask

  // Header hunt and frame collection, one received byte
  task automatic parse_byte(input byte_t b);
    case (phase)
      HUNT_SECOND: begin
        if (b == HDR_2) begin
          frame_bytes[1] = b;
          byte_pos       = IDX_FIRST_DATA;
          frame_sum      = '0;
          phase          = COLLECT;
        end else begin
          // the rejected byte is not retried as a first header byte
          phase = HUNT_FIRST;
        end
      end
      COLLECT: begin
        frame_bytes[byte_pos] = b;
        if (byte_pos == IDX_LAST) begin
          close_frame(b);
          phase = HUNT_FIRST;
        end else begin
          frame_sum = frame_sum + b;
          byte_pos  = byte_pos + 1'b1;
        end
      end
      default: begin
        if (b == HDR_A || b == HDR_B) begin
          frame_bytes[0] = b;
          phase          = HUNT_SECOND;
        end
      end
    endcase
  endtask

  task automatic check_result(input logic [RES_W-1:0] data);
    result_t got;
    result_t want;
    got = data[RES_BITS-1:0];
    if (data[RES_W-1:RES_BITS] !== '0)
      report_fail($sformatf("pad bits not zero: 0x%0h", data[RES_W-1:RES_BITS]));
    if (expected_q.size() == 0) begin
      report_fail("result item with no frame pending");
    end else begin
      want = expected_q.pop_front();
      compare_field("checksum_ok", got.checksum_ok, want.checksum_ok);
      compare_field("header_byte", got.header_byte, want.header_byte);
      compare_field("voltage_param", got.voltage_param, want.voltage_param);
      compare_field("voltage_raw", got.voltage_raw, want.voltage_raw);
      compare_field("current_param", got.current_param, want.current_param);
      compare_field("current_raw", got.current_raw, want.current_raw);
      compare_field("power_param", got.power_param, want.power_param);
      compare_field("power_raw", got.power_raw, want.power_raw);
      compare_field("status_byte", got.status_byte, want.status_byte);
      compare_field("energy_total", got.energy_total, want.energy_total);
    end
  endtask

  // Watch both channels
  always @(posedge clk) begin
    if (rst) begin
      phase        = HUNT_FIRST;
      byte_pos     = '0;
      frame_sum    = '0;
      toggle_seen  = 1'b0;
      overflow_cnt = '0;
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready)
        check_result(m_tdata);
      if (s_tvalid && s_tready)
        parse_byte(s_tdata);
    end
    pending_results = expected_q.size();
  end

endmodule

@@ tb/power_meter_frame_parser_unit_tb.sv @@
`timescale 1ns / 1ps

module power_meter_frame_parser_unit_tb;
  import pmfp_pkg::*;

  localparam int unsigned RANDOM_BYTES = 680;

  // Idling levels
  localparam int unsigned IDLE_NONE  = 0;
  localparam int unsigned IDLE_LIGHT = 1;
  localparam int unsigned IDLE_HEAVY = 2;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  byte_t            s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;

  int unsigned      fail_count;
  int unsigned      pending_results;
  int unsigned      good_frames;
  int unsigned      bad_frames;

  int unsigned      idle_level = IDLE_LIGHT;
  int unsigned      bytes_sent;
  int unsigned      stall_left;
  byte_t            frame_buf [FRAME_LEN];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  power_meter_frame_parser_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  power_meter_frame_parser_unit_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .good_frames     (good_frames),
    .bad_frames      (bad_frames)
  );

  function automatic bit idle_now();
    case (idle_level)
      IDLE_HEAVY: return $urandom_range(0, 3) == 0;
      IDLE_LIGHT: return $urandom_range(0, 15) == 0;
      default:    return 1'b0;
    endcase
  endfunction

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_now()) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One received byte, with an optional gap in front
  task automatic send_byte(input byte_t b);
    if (idle_now()) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Fill in the checksum (spoiled if asked) and send the whole frame
  task automatic send_frame(input bit spoil);
    byte_t sum;
    sum          = '0;
    frame_buf[1] = HDR_2;
    for (int k = 2; k < FRAME_LEN - 1; k++)
      sum = sum + frame_buf[k];
    frame_buf[FRAME_LEN-1] = spoil ? sum + byte_t'($urandom_range(1, 255)) : sum;
    for (int k = 0; k < FRAME_LEN; k++)
      send_byte(frame_buf[k]);
  endtask

  task automatic random_payload();
    for (int k = 2; k < FRAME_LEN - 1; k++)
      frame_buf[k] = byte_t'($urandom_range(0, 255));
  endtask

  initial begin
    int unsigned pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-ones frame, status bit 7 set, so the overflow count bumps
    frame_buf[0] = HDR_A;
    for (int k = 2; k < FRAME_LEN - 1; k++)
      frame_buf[k] = 8'hFF;
    send_frame(1'b0);

    // All-zero frame on the other header, status bit 7 falls: bumps again
    frame_buf[0] = HDR_B;
    for (int k = 2; k < FRAME_LEN - 1; k++)
      frame_buf[k] = 8'h00;
    send_frame(1'b0);

    // Bad checksum: zero result, counter untouched
    frame_buf[0] = HDR_A;
    random_payload();
    frame_buf[20][7] = 1'b1;
    send_frame(1'b1);

    // Wrong second header byte that is itself a first header byte, then a
    // stray second header byte while hunting, then a header with a bad second byte
    send_byte(HDR_A);
    send_byte(HDR_A);
    send_byte(HDR_2);
    send_byte(HDR_B);
    send_byte(8'h00);

    // Good frame with status bit 7 unchanged: no bump
    frame_buf[0] = HDR_B;
    random_payload();
    frame_buf[20][7] = 1'b0;
    send_frame(1'b0);

    // Frame right after a frame, bit 7 set: bump
    frame_buf[0] = HDR_A;
    random_payload();
    frame_buf[20][7] = 1'b1;
    send_frame(1'b0);

    // Random part: mostly well-formed frames, some noise and broken headers
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent < 200)
        idle_level = IDLE_HEAVY;
      else if (bytes_sent < 380)
        idle_level = IDLE_NONE;
      else if (bytes_sent < 560)
        idle_level = IDLE_LIGHT;
      else
        idle_level = IDLE_NONE;

      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        frame_buf[0] = $urandom_range(0, 1) ? HDR_A : HDR_B;
        random_payload();
        send_frame($urandom_range(0, 9) == 0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom_range(0, 255)));
      end else begin
        send_byte($urandom_range(0, 1) ? HDR_A : HDR_B);
        send_byte(byte_t'($urandom_range(0, 255)));
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then keep watching for anything unexpected
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d frame results: %0d good checksum, %0d bad checksum",
             good_frames + bad_frames, good_frames, bad_frames);
    $display("headers, broken headers and noise bytes mixed with sender gaps and stalls");
    if (fail_count == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/pmfp_pkg.sv
src/power_meter_frame_parser_unit.sv
tb/power_meter_frame_parser_unit_checker.sv
tb/power_meter_frame_parser_unit_tb.sv
